[design/ffsba_pkg.sv]
// shared constants, item types and controller/datapath interface types for the sector allocator
package ffsba_pkg;

    // map geometry
    localparam int NUM_SECTORS = 4096;
    localparam int MAX_RUN     = 64;
    localparam int WORD_W      = 64;
    localparam int NUM_WORDS   = NUM_SECTORS / WORD_W;
    localparam int WIN_W       = 2 * WORD_W;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int WADDR_W     = $clog2(NUM_WORDS);
    localparam int SEC_W       = 12;
    localparam int CNT_W       = 7;
    localparam int SIZE_W      = 13;
    localparam int LOG_W       = 3;

    // map word 0 after reset: free-map and root directory sectors in use
    localparam logic [WORD_W-1:0] RESET_WORD0 = WORD_W'(3);

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_DEVICE_SECTORS = 1'b0;
    localparam logic [SIZE_W-1:0] DEVICE_SECTORS_RST = SIZE_W'(NUM_SECTORS);

    // operation codes
    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_BADRANGE = 2'd2;

    typedef struct packed {
        logic             func;
        logic [CNT_W-1:0] count;
        logic [SEC_W-1:0] start_sector;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [SEC_W-1:0] first_sector;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_EVAL,
        S_SCAN_TEST,
        S_MARK_RD_LO,
        S_MARK_RD_HI,
        S_MARK_CAP_HI,
        S_MARK_WR_LO,
        S_MARK_WR_HI,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       load_item;
        logic       rd_scan;
        logic       eval;
        logic       pick;
        logic       rd_lo;
        logic       rd_hi;
        logic       cap_lo;
        logic       cap_hi;
        logic       wr_lo;
        logic       wr_hi;
        logic       set_status;
        logic [1:0] status;
        logic       load_result;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_release;
        logic count_zero;
        logic count_over;
        logic range_bad;
        logic hit_any;
        logic scan_last;
        logic rel_conflict;
    } t_dp_sts;

endpackage

[design/first_fit_sector_bitmap_allocator.sv]
// top level of the first-fit sector bitmap allocator: config register and unit wiring
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_in_item (func, count, start_sector)
//  out       output     o_out_valid / i_out_stall o_out_item (status, first_sector)
//  config    input      psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// an allocate scans the 64-sector map words in turn, evaluating one word and testing it
// while the next is fetched, over the 64 words of the map, paced by the single read port
// of the map ram, then runs a read-modify-write mark pass; a release runs only the mark
// pass, and a zero or oversized count or an out-of-range release goes straight to the result.
// reset marks sectors 0 and 1 used through per-row valid bits, with no clearing pass.
// a new item is accepted while a result waits in the output register; a stalled result
// holds the next item's completion until it is taken.
module first_fit_sector_bitmap_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ffsba_pkg::t_in_item             i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ffsba_pkg::t_out_item            o_out_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ffsba_pkg::PADDR_W-1:0]   paddr,
    input  logic [ffsba_pkg::PDATA_W-1:0]   pwdata,
    output logic [ffsba_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready
);

    localparam int SIZE_W = ffsba_pkg::SIZE_W;

    logic [SIZE_W-1:0]  r_device_sectors;
    logic [SIZE_W-1:0]  size;
    logic               cfg_wr;
    logic               reg_idx;
    ffsba_pkg::t_dp_cmd cmd;
    ffsba_pkg::t_dp_sts sts;

    // configuration register write
    assign pready  = 1'b1;
    assign reg_idx = paddr[ffsba_pkg::PADDR_W-1];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_sectors <= ffsba_pkg::DEVICE_SECTORS_RST;
        end else if (cfg_wr && reg_idx == ffsba_pkg::REG_DEVICE_SECTORS) begin
            r_device_sectors <= pwdata[SIZE_W-1:0];
        end
    end

    // register read back
    always_comb begin
        prdata = '0;
        if (reg_idx == ffsba_pkg::REG_DEVICE_SECTORS) begin
            prdata = ffsba_pkg::PDATA_W'(r_device_sectors);
        end
    end

    // device size clamped to the map
    assign size = (r_device_sectors > ffsba_pkg::DEVICE_SECTORS_RST) ?
                  ffsba_pkg::DEVICE_SECTORS_RST : r_device_sectors;

    ffsba_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ffsba_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in_item  (i_in_item),
        .i_size     (size),
        .o_out_item (o_out_item)
    );

endmodule

[design/ffsba_ram.sv]
// generic single-write, single-read ram with registered read data
module ffsba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/ffsba_dp.sv]
// datapath: used-sector map, word scanner, run detector and mark/free read-modify-write
module ffsba_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffsba_pkg::t_dp_cmd            i_cmd,
    output ffsba_pkg::t_dp_sts            o_sts,
    input  ffsba_pkg::t_in_item           i_in_item,
    input  logic [ffsba_pkg::SIZE_W-1:0]  i_size,
    output ffsba_pkg::t_out_item          o_out_item
);

    localparam int WORD_W  = ffsba_pkg::WORD_W;
    localparam int WIN_W   = ffsba_pkg::WIN_W;
    localparam int BIT_W   = ffsba_pkg::BIT_W;
    localparam int WADDR_W = ffsba_pkg::WADDR_W;
    localparam int SEC_W   = ffsba_pkg::SEC_W;
    localparam int CNT_W   = ffsba_pkg::CNT_W;
    localparam int SIZE_W  = ffsba_pkg::SIZE_W;
    localparam int LOG_W   = ffsba_pkg::LOG_W;
    localparam int NUM_WORDS_W = ffsba_pkg::NUM_WORDS;

    // lowest set bit of a word
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // position of the highest set bit of a run length
    function automatic logic [LOG_W-1:0] run_log(input logic [CNT_W-1:0] c);
        logic [LOG_W-1:0] m;
        m = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (c[i]) begin
                m = LOG_W'(i);
            end
        end
        return m;
    endfunction

    // item registers
    logic                 r_func;
    logic [CNT_W-1:0]     r_count;
    logic [SEC_W-1:0]     r_base;
    logic [LOG_W-1:0]     r_run_log;
    logic [BIT_W-1:0]     r_run_ext;
    logic [1:0]           r_status;
    logic [SEC_W-1:0]     r_first;

    // scan registers
    logic [WADDR_W-1:0]   r_word;
    logic                 r_last;
    logic [WORD_W-1:0]    r_prev_free;
    logic [WORD_W-1:0]    r_hit;
    logic [WADDR_W-1:0]   r_hit_word;

    // map access registers
    logic [NUM_WORDS_W-1:0] r_vld;
    logic [WADDR_W-1:0]   r_rd_addr;
    logic [WORD_W-1:0]    r_lo;
    logic [WORD_W-1:0]    r_hi;

    ffsba_pkg::t_out_item r_out_item;

    // combinational nets
    logic [WORD_W-1:0]    ram_q;
    logic [WORD_W-1:0]    eff_word;
    logic [WORD_W-1:0]    word_mask;
    logic [WORD_W-1:0]    free_cur;
    logic [WIN_W-1:0]     g [0:(1 << LOG_W) - 1];
    logic [WIN_W-1:0]     g_sel;
    logic [WIN_W-1:0]     hit_win;
    logic [WADDR_W-1:0]   lo_addr;
    logic [WADDR_W-1:0]   hi_addr;
    logic [WADDR_W-1:0]   rd_addr;
    logic                 rd_en;
    logic [WIN_W-1:0]     run_mask;
    logic [WORD_W-1:0]    mask_lo;
    logic [WORD_W-1:0]    mask_hi;
    logic [WORD_W-1:0]    new_lo;
    logic [WORD_W-1:0]    new_hi;
    logic                 wr_en;
    logic [WADDR_W-1:0]   wr_addr;
    logic [WORD_W-1:0]    wr_data;
    logic [SEC_W-1:0]     end_sec;
    logic [SEC_W-1:0]     pick_first;
    logic [CNT_W-1:0]     in_run_ext;
    logic [LOG_W-1:0]     in_run_log;

    // map storage, one row per 64 sectors
    ffsba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ffsba_pkg::NUM_WORDS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    // run length split into a power of two and an overlap offset
    assign in_run_log = run_log(i_in_item.count);
    assign in_run_ext = i_in_item.count - (CNT_W'(1) << in_run_log);

    // read address select
    assign lo_addr = r_base[SEC_W-1:BIT_W];
    assign hi_addr = lo_addr + WADDR_W'(1);
    assign rd_en   = i_cmd.rd_scan | i_cmd.rd_lo | i_cmd.rd_hi;
    always_comb begin
        rd_addr = r_word;
        if (i_cmd.rd_lo) begin
            rd_addr = lo_addr;
        end else if (i_cmd.rd_hi) begin
            rd_addr = hi_addr;
        end
    end

    // rows never written read as their reset contents
    always_comb begin
        if (r_vld[r_rd_addr]) begin
            eff_word = ram_q;
        end else if (r_rd_addr == '0) begin
            eff_word = ffsba_pkg::RESET_WORD0;
        end else begin
            eff_word = '0;
        end
    end

    // sectors at or beyond the device size count as used
    always_comb begin
        if (i_size[SIZE_W-1:BIT_W] > {1'b0, r_word}) begin
            word_mask = '1;
        end else if (i_size[SIZE_W-1:BIT_W] == {1'b0, r_word}) begin
            word_mask = ~({WORD_W{1'b1}} << i_size[BIT_W-1:0]);
        end else begin
            word_mask = '0;
        end
    end
    assign free_cur = ~eff_word & word_mask;

    // free-run ladder over previous and current word: g[k] marks runs of 2^k ending here
    always_comb begin
        g[0] = {free_cur, r_prev_free};
        for (int k = 1; k < (1 << LOG_W); k++) begin
            g[k] = g[k-1] & (g[k-1] << (1 << (k - 1)));
        end
    end
    assign g_sel   = g[r_run_log];
    assign hit_win = g_sel & (g_sel << r_run_ext);

    // first sector of the earliest run found
    assign end_sec    = {r_hit_word, lowest_set(r_hit)};
    assign pick_first = end_sec + SEC_W'(1) - SEC_W'(r_count);

    // run mask over the two words that a run can touch
    assign run_mask = (~({WIN_W{1'b1}} << r_count)) << r_base[BIT_W-1:0];
    assign mask_lo  = run_mask[WORD_W-1:0];
    assign mask_hi  = run_mask[WIN_W-1:WORD_W];
    assign new_lo   = (r_func == ffsba_pkg::FUNC_RELEASE) ? (r_lo & ~mask_lo) : (r_lo | mask_lo);
    assign new_hi   = (r_func == ffsba_pkg::FUNC_RELEASE) ? (r_hi & ~mask_hi) : (r_hi | mask_hi);

    // write port select
    assign wr_en   = i_cmd.wr_lo | (i_cmd.wr_hi & (|mask_hi));
    assign wr_addr = i_cmd.wr_lo ? lo_addr : hi_addr;
    assign wr_data = i_cmd.wr_lo ? new_lo : new_hi;

    // row valid bits and read address tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_addr <= rd_addr;
        end
    end

    // item, scan and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_func      <= i_in_item.func;
            r_count     <= i_in_item.count;
            r_base      <= i_in_item.start_sector;
            r_run_log   <= in_run_log;
            r_run_ext   <= in_run_ext[BIT_W-1:0];
            r_status    <= ffsba_pkg::ST_OK;
            r_first     <= '0;
            r_word      <= '0;
            r_prev_free <= '0;
        end
        if (i_cmd.eval) begin
            r_hit       <= hit_win[WIN_W-1:WORD_W];
            r_hit_word  <= r_word;
            r_prev_free <= free_cur;
            r_last      <= (r_word == WADDR_W'(ffsba_pkg::NUM_WORDS - 1));
            r_word      <= r_word + WADDR_W'(1);
        end
        if (i_cmd.pick) begin
            r_first <= pick_first;
            r_base  <= pick_first;
        end
        if (i_cmd.cap_lo) begin
            r_lo <= eff_word;
        end
        if (i_cmd.cap_hi) begin
            r_hi <= eff_word;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.load_result) begin
            r_out_item.status       <= r_status;
            r_out_item.first_sector <= r_first;
        end
    end

    // status toward the controller
    always_comb begin
        o_sts.is_release   = (r_func == ffsba_pkg::FUNC_RELEASE);
        o_sts.count_zero   = (r_count == '0);
        o_sts.count_over   = (r_count > CNT_W'(ffsba_pkg::MAX_RUN));
        o_sts.range_bad    = ((SIZE_W'(r_base) + SIZE_W'(r_count)) > i_size);
        o_sts.hit_any      = |r_hit;
        o_sts.scan_last    = r_last;
        o_sts.rel_conflict = o_sts.is_release &&
                             (((r_lo & mask_lo) != mask_lo) || ((r_hi & mask_hi) != mask_hi));
    end

    assign o_out_item = r_out_item;

endmodule

[design/ffsba_ctl.sv]
// controller: sequences item intake, word scan, mark/free pass and result handoff
module ffsba_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ffsba_pkg::t_dp_cmd o_cmd,
    input  ffsba_pkg::t_dp_sts i_sts
);

    ffsba_pkg::t_state r_state;
    ffsba_pkg::t_state n_state;
    logic              r_out_valid;
    logic              n_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffsba_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ffsba_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ffsba_pkg::S_CHECK;
                end
            end
            ffsba_pkg::S_CHECK: begin
                if (i_sts.is_release) begin
                    if (i_sts.count_over || i_sts.range_bad) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ffsba_pkg::ST_BADRANGE;
                        n_state          = ffsba_pkg::S_DONE;
                    end else if (i_sts.count_zero) begin
                        n_state = ffsba_pkg::S_DONE;
                    end else begin
                        n_state = ffsba_pkg::S_MARK_RD_LO;
                    end
                end else begin
                    if (i_sts.count_over) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ffsba_pkg::ST_NOSPACE;
                        n_state          = ffsba_pkg::S_DONE;
                    end else if (i_sts.count_zero) begin
                        n_state = ffsba_pkg::S_DONE;
                    end else begin
                        n_state = ffsba_pkg::S_SCAN_RD;
                    end
                end
            end
            ffsba_pkg::S_SCAN_RD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = ffsba_pkg::S_SCAN_EVAL;
            end
            ffsba_pkg::S_SCAN_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = ffsba_pkg::S_SCAN_TEST;
            end
            // test the word just evaluated while fetching the next one
            ffsba_pkg::S_SCAN_TEST: begin
                if (i_sts.hit_any) begin
                    o_cmd.pick = 1'b1;
                    n_state    = ffsba_pkg::S_MARK_RD_LO;
                end else if (i_sts.scan_last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ffsba_pkg::ST_NOSPACE;
                    n_state          = ffsba_pkg::S_DONE;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state       = ffsba_pkg::S_SCAN_EVAL;
                end
            end
            ffsba_pkg::S_MARK_RD_LO: begin
                o_cmd.rd_lo = 1'b1;
                n_state     = ffsba_pkg::S_MARK_RD_HI;
            end
            ffsba_pkg::S_MARK_RD_HI: begin
                o_cmd.rd_hi  = 1'b1;
                o_cmd.cap_lo = 1'b1;
                n_state      = ffsba_pkg::S_MARK_CAP_HI;
            end
            ffsba_pkg::S_MARK_CAP_HI: begin
                o_cmd.cap_hi = 1'b1;
                n_state      = ffsba_pkg::S_MARK_WR_LO;
            end
            ffsba_pkg::S_MARK_WR_LO: begin
                if (i_sts.rel_conflict) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ffsba_pkg::ST_BADRANGE;
                    n_state          = ffsba_pkg::S_DONE;
                end else begin
                    o_cmd.wr_lo = 1'b1;
                    n_state     = ffsba_pkg::S_MARK_WR_HI;
                end
            end
            ffsba_pkg::S_MARK_WR_HI: begin
                o_cmd.wr_hi = 1'b1;
                n_state     = ffsba_pkg::S_DONE;
            end
            // hand the result over once the output register is free
            ffsba_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_result = 1'b1;
                    n_out_valid       = 1'b1;
                    n_state           = ffsba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffsba_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ffsba_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[dv/ffsba_result_checker.sv]
// checker for the sector allocator: shadow used-sector map, result prediction and comparison
module ffsba_result_checker
    import ffsba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_item,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [PADDR_W-1:0]   i_paddr,
    input  logic [PDATA_W-1:0]   i_pwdata,
    input  logic                 i_pready,
    input  logic                 i_end,
    output int                   o_errors
);

    localparam logic [PADDR_W-1:0] DEV_SECTORS_ADDR = PADDR_W'(4 * int'(REG_DEVICE_SECTORS));

    bit                sector_used [NUM_SECTORS];
    logic [SIZE_W-1:0] device_size_reg;
    t_out_item         expected_results [$];
    int                mismatch_count;
    bit                end_checked;

    assign o_errors = mismatch_count;

    task automatic flag_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // shadow of the used map, then one allocate or release applied to it
    function automatic t_out_item apply_sector_op(t_in_item req);
        t_out_item res;
        int        span;
        int        cnt;
        int        base;
        int        run_len;
        int        i;
        bit        found;
        span = (int'(device_size_reg) > NUM_SECTORS) ? NUM_SECTORS : int'(device_size_reg);
        cnt = int'(req.count);
        base = int'(req.start_sector);
        res.status = ST_OK;
        res.first_sector = '0;
        if (req.func == FUNC_ALLOC) begin
            if (cnt > MAX_RUN) begin
                res.status = ST_NOSPACE;
            end else if (cnt != 0) begin
                // first fit: lowest run of free sectors below the device size
                run_len = 0;
                found = 1'b0;
                for (i = 0; i < span && !found; i++) begin
                    run_len = sector_used[i] ? 0 : run_len + 1;
                    if (run_len == cnt) begin
                        base = i + 1 - cnt;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    for (i = base; i < base + cnt; i++)
                        sector_used[i] = 1'b1;
                    res.first_sector = SEC_W'(base);
                end else begin
                    res.status = ST_NOSPACE;
                end
            end
        end else begin
            // release: in range and every sector in use, or nothing changes
            if (cnt > MAX_RUN || base + cnt > span) begin
                res.status = ST_BADRANGE;
            end else begin
                for (i = base; i < base + cnt; i++)
                    if (!sector_used[i])
                        res.status = ST_BADRANGE;
                if (res.status == ST_OK)
                    for (i = base; i < base + cnt; i++)
                        sector_used[i] = 1'b0;
            end
        end
        return res;
    endfunction

    // watch the channels and the config port at each rising edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (sector_used[i])
                sector_used[i] = (i < 2);
            device_size_reg = DEVICE_SECTORS_RST;
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == DEV_SECTORS_ADDR)
                device_size_reg = i_pwdata[SIZE_W-1:0];
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result status %0d sector %0d",
                                            i_out_item.status, i_out_item.first_sector));
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_item.status !== want.status)
                        flag_mismatch($sformatf("status %0d, predicted %0d",
                                                i_out_item.status, want.status));
                    if (i_out_item.first_sector !== want.first_sector)
                        flag_mismatch($sformatf("first_sector %0d, predicted %0d",
                                                i_out_item.first_sector, want.first_sector));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(apply_sector_op(i_in_item));
            if (i_end && !end_checked) begin
                end_checked = 1'b1;
                if (expected_results.size() != 0)
                    flag_mismatch($sformatf("%0d predicted results never came out",
                                            expected_results.size()));
            end
        end
    end

endmodule

[dv/first_fit_sector_bitmap_allocator_tb.sv]
// testbench top for the sector allocator: clock, reset, request stimulus, config writes, verdict
module first_fit_sector_bitmap_allocator_tb;
    import ffsba_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int PHASE_ITEMS = 60;
    localparam logic [PADDR_W-1:0] DEV_SECTORS_ADDR = PADDR_W'(4 * int'(REG_DEVICE_SECTORS));

    typedef struct {
        int base;
        int len;
    } t_run;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_item = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_item;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 run_end = 1'b0;
    int                   error_count;

    int       send_idle_pct = 0;
    int       stall_pct = 0;
    int       idle_cycles = 0;
    t_in_item requests_in_flight [$];
    t_run     live_runs [$];
    int       phase_sizes [8] = '{4096, 300, 8191, 130, 2, 4096, 0, 1000};
    int       items_sent = 0;
    int       sizes_written = 0;
    int       runs_granted = 0;
    int       runs_released = 0;
    int       nospace_count = 0;
    int       badrange_count = 0;

    first_fit_sector_bitmap_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    ffsba_result_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_item  (o_out_item),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .i_end       (run_end),
        .o_errors    (error_count)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // track requests in flight and the runs currently held, for release stimulus
    always @(posedge i_clk) begin
        t_in_item req;
        if (o_out_valid && !i_out_stall && requests_in_flight.size() != 0) begin
            req = requests_in_flight.pop_front();
            if (o_out_item.status == ST_OK) begin
                if (req.func == FUNC_RELEASE)
                    runs_released++;
                else if (req.count != 0) begin
                    runs_granted++;
                    live_runs.push_back('{int'(o_out_item.first_sector), int'(req.count)});
                end
            end else if (o_out_item.status == ST_NOSPACE)
                nospace_count++;
            else
                badrange_count++;
        end
        if (i_in_valid && !o_in_stall) begin
            requests_in_flight.push_back(i_in_item);
            items_sent++;
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_in_item mk_req(logic func, int cnt, int sector);
        t_in_item req;
        req.func = func;
        req.count = CNT_W'(cnt);
        req.start_sector = SEC_W'(sector);
        return req;
    endfunction

    // mostly allocates and releases of held runs, the rest random noise
    function automatic t_in_item next_random_request();
        t_in_item req;
        t_run     held;
        int       pick;
        int       idx;
        int       part;
        pick = $urandom_range(99);
        req = mk_req(FUNC_ALLOC, 1, $urandom);
        if (pick < 45) begin
            pick = $urandom_range(9);
            if (pick < 6)
                req.count = CNT_W'($urandom_range(1, 8));
            else if (pick < 9)
                req.count = CNT_W'($urandom_range(1, MAX_RUN));
            else
                req.count = CNT_W'($urandom_range(0, 127));
        end else if (pick < 82 && live_runs.size() != 0) begin
            idx = $urandom_range(live_runs.size() - 1);
            held = live_runs[idx];
            live_runs.delete(idx);
            part = ($urandom_range(3) == 0) ? $urandom_range(1, held.len) : held.len;
            req = mk_req(FUNC_RELEASE, part, held.base);
            if (part < held.len)
                live_runs.push_back('{held.base + part, held.len - part});
        end else begin
            req.func = 1'($urandom_range(1));
            req.count = CNT_W'($urandom_range(0, 127));
        end
        return req;
    endfunction

    // present one request, with random sender gaps, and hold it until taken
    task automatic send_item(t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item = req;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        while (requests_in_flight.size() != 0)
            @(negedge i_clk);
    endtask

    // config write: setup cycle then access cycle, only with nothing in flight
    task automatic set_device_size(int sectors);
        drain_results();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = DEV_SECTORS_ADDR;
        pwdata = PDATA_W'(sectors);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        sizes_written++;
    endtask

    // stimulus
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero and oversized counts, full-device edges, system sectors
        send_item(mk_req(FUNC_ALLOC, 0, 4095));
        send_item(mk_req(FUNC_ALLOC, 1, 0));
        send_item(mk_req(FUNC_ALLOC, MAX_RUN, 0));
        send_item(mk_req(FUNC_ALLOC, MAX_RUN + 1, 0));
        send_item(mk_req(FUNC_ALLOC, 127, 4095));
        send_item(mk_req(FUNC_RELEASE, 2, 0));
        send_item(mk_req(FUNC_RELEASE, 1, 0));
        send_item(mk_req(FUNC_ALLOC, 2, 0));
        send_item(mk_req(FUNC_RELEASE, MAX_RUN, 3));
        send_item(mk_req(FUNC_RELEASE, MAX_RUN + 1, 3));
        send_item(mk_req(FUNC_RELEASE, 0, 4095));
        send_item(mk_req(FUNC_RELEASE, 2, 4095));
        send_item(mk_req(FUNC_RELEASE, 127, 4095));

        // device size above the map is clamped to the map
        set_device_size(8191);
        send_item(mk_req(FUNC_ALLOC, MAX_RUN, 0));
        send_item(mk_req(FUNC_RELEASE, 0, 4095));
        send_item(mk_req(FUNC_RELEASE, 1, 4095));

        // devices no larger than the two system sectors
        set_device_size(0);
        send_item(mk_req(FUNC_ALLOC, 1, 0));
        send_item(mk_req(FUNC_RELEASE, 0, 0));
        send_item(mk_req(FUNC_RELEASE, 0, 1));
        set_device_size(1);
        send_item(mk_req(FUNC_RELEASE, 0, 1));
        send_item(mk_req(FUNC_ALLOC, 1, 0));
        set_device_size(2);
        send_item(mk_req(FUNC_RELEASE, 2, 0));
        send_item(mk_req(FUNC_ALLOC, 2, 0));
        send_item(mk_req(FUNC_ALLOC, 1, 0));
        send_item(mk_req(FUNC_RELEASE, 0, 4095));

        // random phases, each with its own device size and idle pattern
        for (int p = 0; p < 8; p++) begin
            set_device_size(phase_sizes[p]);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 76;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 76;
                end
                default: begin
                    send_idle_pct = 21;
                    stall_pct = 21;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(next_random_request());
                if ((p == 0 && n == PHASE_ITEMS / 2) || $urandom_range(49) == 0)
                    drain_results();
            end
        end

        // let everything come out, then a margin for a late extra result
        drain_results();
        stall_pct = 0;
        repeat (150) @(posedge i_clk);
        run_end = 1'b1;
        @(posedge i_clk);
        @(negedge i_clk);

        $display("covered %0d requests across %0d device-size writes, idle and stall mixes",
                 items_sent, sizes_written);
        $display("%0d runs granted, %0d released, %0d refused for space, %0d bad ranges",
                 runs_granted, runs_released, nospace_count, badrange_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
